/* design/point_polyline_distance_macros.svh */
// Assertion macros for the point-to-polyline distance block.
`ifndef POINT_POLYLINE_DISTANCE_MACROS_SVH
`define POINT_POLYLINE_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge out of reset
`define PPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppd assertion failed");

// Next-cycle implication, checked on every rising edge out of reset
`define PPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppd assertion failed");

`else

`define PPD_ASSERT_NOW(lbl, ante, cons)
`define PPD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/ppd_pkg.sv */
// Shared constants, types and codes of the point-to-polyline distance block.
`default_nettype none

package ppd_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int OPND_W  = DIFF_W + 1;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int DOT_W   = SQ_W + 1;
    localparam int NUM_W   = 2 * SQ_W;
    localparam int ACC_W   = NUM_W + 2;
    localparam int DIST_W  = SQ_W / 2;
    localparam int VTX_W   = 3 * COORD_W;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;

    // Destination of a finished sum of products
    typedef enum logic [3:0] {
        DST_DD,
        DST_DOT0,
        DST_DOT1,
        DST_WW,
        DST_VV,
        DST_C0,
        DST_C1,
        DST_C2,
        DST_N
    } dest_t;

    // Left shift applied to a product before it is accumulated
    typedef enum logic [1:0] {
        SH_0,
        SH_26,
        SH_50
    } shift_t;

    typedef struct packed {
        logic                     issue;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
        logic                     neg;
        shift_t                   shift;
        logic                     last;
        dest_t                    dest;
    } mac_op_t;

    typedef struct packed {
        logic                    valid;
        dest_t                   dest;
        logic signed [ACC_W-1:0] value;
    } mac_res_t;

endpackage

`default_nettype wire

/* design/ppd_mac.sv */
// Shared multiply-accumulate unit: one registered 26x26 product per cycle.
`default_nettype none

module ppd_mac (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ppd_pkg::mac_op_t op,
    output ppd_pkg::mac_res_t     res
);
    import ppd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     tag_valid_reg;
    logic                     tag_neg_reg;
    shift_t                   tag_shift_reg;
    logic                     tag_last_reg;
    dest_t                    tag_dest_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  ext;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  sum;

    // Register the product and the tag that travels with it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            tag_valid_reg <= op.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= op.a * op.b;
        tag_neg_reg   <= op.neg;
        tag_shift_reg <= op.shift;
        tag_last_reg  <= op.last;
        tag_dest_reg  <= op.dest;
    end

    // Align, sign and add the registered product
    always_comb
    begin
        ext = ACC_W'(prod_reg);
        case (tag_shift_reg)
            SH_0:    term = ext;
            SH_26:   term = ext <<< 26;
            SH_50:   term = ext <<< 50;
            default: term = ext;
        endcase
        if (tag_neg_reg)
        begin
            term = -term;
        end
        sum = acc_reg + term;
        acc_next = acc_reg;
        if (tag_valid_reg)
        begin
            acc_next = tag_last_reg ? '0 : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // Hand out the sum when the last term of a group lands
    assign res.valid = tag_valid_reg && tag_last_reg;
    assign res.dest  = tag_dest_reg;
    assign res.value = sum;

endmodule

`default_nettype wire

/* design/ppd_div.sv */
// Restoring divider, one quotient bit per cycle, for the perpendicular distance.
`default_nettype none

module ppd_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ppd_pkg::NUM_W-1:0]   num,
    input  wire logic [ppd_pkg::SQ_W-1:0]    den,
    output logic                             busy,
    output logic [ppd_pkg::SQ_W-1:0]         quo
);
    import ppd_pkg::*;

    localparam int CNT_DW = $clog2(SQ_W);

    logic [SQ_W-1:0]   rem_reg;
    logic [SQ_W-1:0]   low_reg;
    logic [SQ_W-1:0]   den_reg;
    logic [CNT_DW-1:0] cnt_reg;
    logic              busy_reg;
    logic [SQ_W:0]     sh;
    logic [SQ_W:0]     diff;
    logic              ge;

    // Shift in one dividend bit and try the subtraction
    always_comb
    begin
        sh   = {rem_reg, low_reg[SQ_W-1]};
        ge   = sh >= {1'b0, den_reg};
        diff = sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_DW'(SQ_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The quotient never reaches 2^SQ_W, so the upper half seeds the remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:SQ_W];
            low_reg <= num[SQ_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[SQ_W-1:0] : sh[SQ_W-1:0];
            low_reg <= {low_reg[SQ_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = low_reg;

endmodule

`default_nettype wire

/* design/ppd_sqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none

module ppd_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ppd_pkg::SQ_W-1:0]   x,
    output logic                            busy,
    output logic [ppd_pkg::DIST_W-1:0]      root
);
    import ppd_pkg::*;

    localparam int REM_W  = DIST_W + 3;
    localparam int CNT_SW = $clog2(DIST_W);

    logic [SQ_W-1:0]   x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIST_W-1:0] root_reg;
    logic [CNT_SW-1:0] cnt_reg;
    logic              busy_reg;
    logic [REM_W-1:0]  sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // Bring down two bits and test root*4+1
    always_comb
    begin
        sh    = {rem_reg[REM_W-3:0], x_reg[SQ_W-1:SQ_W-2]};
        trial = REM_W'({root_reg, 2'b01});
        ge    = sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_SW'(DIST_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= ge ? (sh - trial) : sh;
            root_reg <= {root_reg[DIST_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* design/point_polyline_distance.sv */
// Top level: vertex store, segment sequencer and least-distance tracking.
//
// Input channel (in_valid/in_ready) carries action and a Q11.12 point.
// A clear or append leaves the sequencer idle; an append to a full store is dropped.
// A query walks every segment of the stored polyline through one shared
// multiply-accumulate unit, then takes a floor square root of the least
// squared distance; it yields exactly one transfer on the output channel
// (out_valid/out_ready) with distance and no_segment.
// Per segment, nine more multiplies and a restoring divide are needed only
// when the point projects inside the segment, not onto an endpoint.
// A query on fewer than two vertices answers with no_segment set.
// in_ready is high only while the sequencer is idle; a finished result
// sits in the output register, so a stalled receiver holds only the next
// query, which waits at its end until the register frees.
// Reset empties the polyline and drops any pending result.
`default_nettype none

`include "point_polyline_distance_macros.svh"

module point_polyline_distance (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     action,
    input  wire ppd_pkg::coord_t                coord_x,
    input  wire ppd_pkg::coord_t                coord_y,
    input  wire ppd_pkg::coord_t                coord_z,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [ppd_pkg::DIST_W-1:0]          distance,
    output logic                                no_segment
);
    import ppd_pkg::*;

    localparam logic [4:0] STEP_MUL1_END = 5'd21;
    localparam logic [4:0] STEP_MUL2_END = 5'd31;

    typedef enum logic [14:0] {
        ST_IDLE   = 15'b000000000000001,
        ST_LOAD0  = 15'b000000000000010,
        ST_PRIME  = 15'b000000000000100,
        ST_NEXT   = 15'b000000000001000,
        ST_FETCH  = 15'b000000000010000,
        ST_MUL1   = 15'b000000000100000,
        ST_CHK    = 15'b000000001000000,
        ST_MUL2   = 15'b000000010000000,
        ST_DIVS   = 15'b000000100000000,
        ST_DIVW   = 15'b000001000000000,
        ST_UPD    = 15'b000010000000000,
        ST_SEGEND = 15'b000100000000000,
        ST_SQS    = 15'b001000000000000,
        ST_SQW    = 15'b010000000000000,
        ST_FIN    = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [VTX_W-1:0]  mem [MAX_POINTS];
    logic [VTX_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [4:0]        step_reg;
    logic              found_reg;
    logic [SQ_W-1:0]   best_reg;
    logic [SQ_W-1:0]   e_reg;

    coord_t q_reg  [3];
    coord_t p0_reg [3];
    coord_t p1_reg [3];
    coord_t rd_c   [3];
    diff_t  d_reg  [3];
    diff_t  w_reg  [3];
    diff_t  v_reg  [3];

    logic [SQ_W-1:0]         dd_reg;
    logic signed [DOT_W-1:0] dot0_reg;
    logic signed [DOT_W-1:0] dot1_reg;
    logic [SQ_W-1:0]         ww_reg;
    logic [SQ_W-1:0]         vv_reg;
    logic signed [DOT_W-1:0] c_reg [3];
    logic [NUM_W-1:0]        n_reg;
    logic [SQ_W-1:0]         mag_c [3];

    logic              out_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              noseg_reg;

    logic              in_fire;
    mac_op_t           op;
    mac_res_t          res;
    logic              div_start;
    logic              div_busy;
    logic [SQ_W-1:0]   div_quo;
    logic              sq_start;
    logic              sq_busy;
    logic [DIST_W-1:0] sq_root;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Vertex memory: one write port, one registered read port
    assign rd_addr = (state_reg == ST_LOAD0) ? '0 : ADDR_W'(idx_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (in_fire && action == ACT_APPEND && cnt_reg < CNT_W'(MAX_POINTS))
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= {coord_x, coord_y, coord_z};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_c[0] = rd_data_reg[3*COORD_W-1:2*COORD_W];
    assign rd_c[1] = rd_data_reg[2*COORD_W-1:COORD_W];
    assign rd_c[2] = rd_data_reg[COORD_W-1:0];

    // Magnitudes of the cross product, split into halves for squaring
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_c[k] = c_reg[k][DOT_W-1] ? SQ_W'(-c_reg[k]) : SQ_W'(c_reg[k]);
        end
    end

    // Decode the multiply schedule of one segment
    always_comb
    begin
        op       = '0;
        op.shift = SH_0;
        op.dest  = DST_DD;
        unique case (step_reg)
            5'd0:  begin op.a = OPND_W'(d_reg[0]); op.b = OPND_W'(d_reg[0]); end
            5'd1:  begin op.a = OPND_W'(d_reg[1]); op.b = OPND_W'(d_reg[1]); end
            5'd2:  begin op.a = OPND_W'(d_reg[2]); op.b = OPND_W'(d_reg[2]);
                         op.last = 1'b1; op.dest = DST_DD; end
            5'd3:  begin op.a = OPND_W'(w_reg[0]); op.b = OPND_W'(d_reg[0]); end
            5'd4:  begin op.a = OPND_W'(w_reg[1]); op.b = OPND_W'(d_reg[1]); end
            5'd5:  begin op.a = OPND_W'(w_reg[2]); op.b = OPND_W'(d_reg[2]);
                         op.last = 1'b1; op.dest = DST_DOT0; end
            5'd6:  begin op.a = OPND_W'(v_reg[0]); op.b = OPND_W'(d_reg[0]); end
            5'd7:  begin op.a = OPND_W'(v_reg[1]); op.b = OPND_W'(d_reg[1]); end
            5'd8:  begin op.a = OPND_W'(v_reg[2]); op.b = OPND_W'(d_reg[2]);
                         op.last = 1'b1; op.dest = DST_DOT1; end
            5'd9:  begin op.a = OPND_W'(w_reg[0]); op.b = OPND_W'(w_reg[0]); end
            5'd10: begin op.a = OPND_W'(w_reg[1]); op.b = OPND_W'(w_reg[1]); end
            5'd11: begin op.a = OPND_W'(w_reg[2]); op.b = OPND_W'(w_reg[2]);
                         op.last = 1'b1; op.dest = DST_WW; end
            5'd12: begin op.a = OPND_W'(v_reg[0]); op.b = OPND_W'(v_reg[0]); end
            5'd13: begin op.a = OPND_W'(v_reg[1]); op.b = OPND_W'(v_reg[1]); end
            5'd14: begin op.a = OPND_W'(v_reg[2]); op.b = OPND_W'(v_reg[2]);
                         op.last = 1'b1; op.dest = DST_VV; end
            5'd15: begin op.a = OPND_W'(w_reg[1]); op.b = OPND_W'(d_reg[2]); end
            5'd16: begin op.a = OPND_W'(w_reg[2]); op.b = OPND_W'(d_reg[1]);
                         op.neg = 1'b1; op.last = 1'b1; op.dest = DST_C0; end
            5'd17: begin op.a = OPND_W'(w_reg[2]); op.b = OPND_W'(d_reg[0]); end
            5'd18: begin op.a = OPND_W'(w_reg[0]); op.b = OPND_W'(d_reg[2]);
                         op.neg = 1'b1; op.last = 1'b1; op.dest = DST_C1; end
            5'd19: begin op.a = OPND_W'(w_reg[0]); op.b = OPND_W'(d_reg[1]); end
            5'd20: begin op.a = OPND_W'(w_reg[1]); op.b = OPND_W'(d_reg[0]);
                         op.neg = 1'b1; op.last = 1'b1; op.dest = DST_C2; end
            5'd22: begin op.a = OPND_W'({1'b0, mag_c[0][SQ_W-1:DIFF_W]});
                         op.b = OPND_W'({1'b0, mag_c[0][SQ_W-1:DIFF_W]});
                         op.shift = SH_50; end
            5'd23: begin op.a = OPND_W'({1'b0, mag_c[0][SQ_W-1:DIFF_W]});
                         op.b = OPND_W'({1'b0, mag_c[0][DIFF_W-1:0]});
                         op.shift = SH_26; end
            5'd24: begin op.a = OPND_W'({1'b0, mag_c[0][DIFF_W-1:0]});
                         op.b = OPND_W'({1'b0, mag_c[0][DIFF_W-1:0]}); end
            5'd25: begin op.a = OPND_W'({1'b0, mag_c[1][SQ_W-1:DIFF_W]});
                         op.b = OPND_W'({1'b0, mag_c[1][SQ_W-1:DIFF_W]});
                         op.shift = SH_50; end
            5'd26: begin op.a = OPND_W'({1'b0, mag_c[1][SQ_W-1:DIFF_W]});
                         op.b = OPND_W'({1'b0, mag_c[1][DIFF_W-1:0]});
                         op.shift = SH_26; end
            5'd27: begin op.a = OPND_W'({1'b0, mag_c[1][DIFF_W-1:0]});
                         op.b = OPND_W'({1'b0, mag_c[1][DIFF_W-1:0]}); end
            5'd28: begin op.a = OPND_W'({1'b0, mag_c[2][SQ_W-1:DIFF_W]});
                         op.b = OPND_W'({1'b0, mag_c[2][SQ_W-1:DIFF_W]});
                         op.shift = SH_50; end
            5'd29: begin op.a = OPND_W'({1'b0, mag_c[2][SQ_W-1:DIFF_W]});
                         op.b = OPND_W'({1'b0, mag_c[2][DIFF_W-1:0]});
                         op.shift = SH_26; end
            5'd30: begin op.a = OPND_W'({1'b0, mag_c[2][DIFF_W-1:0]});
                         op.b = OPND_W'({1'b0, mag_c[2][DIFF_W-1:0]});
                         op.last = 1'b1; op.dest = DST_N; end
            default: ;
        endcase
        op.issue = ((state_reg == ST_MUL1) && (step_reg < STEP_MUL1_END)) ||
                   ((state_reg == ST_MUL2) && (step_reg < STEP_MUL2_END));
    end

    ppd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .res   (res)
    );

    assign div_start = (state_reg == ST_DIVS);

    ppd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (n_reg),
        .den   (dd_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign sq_start = (state_reg == ST_SQS);

    ppd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     (best_reg),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    // Store finished sums of products
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            unique case (res.dest)
                DST_DD:   dd_reg   <= res.value[SQ_W-1:0];
                DST_DOT0: dot0_reg <= $signed(res.value[DOT_W-1:0]);
                DST_DOT1: dot1_reg <= $signed(res.value[DOT_W-1:0]);
                DST_WW:   ww_reg   <= res.value[SQ_W-1:0];
                DST_VV:   vv_reg   <= res.value[SQ_W-1:0];
                DST_C0:   c_reg[0] <= $signed(res.value[DOT_W-1:0]);
                DST_C1:   c_reg[1] <= $signed(res.value[DOT_W-1:0]);
                DST_C2:   c_reg[2] <= $signed(res.value[DOT_W-1:0]);
                DST_N:    n_reg    <= res.value[NUM_W-1:0];
                default:  ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && action == ACT_QUERY)
                begin
                    state_next = (cnt_reg >= CNT_W'(2)) ? ST_LOAD0 : ST_FIN;
                end
            end
            ST_LOAD0:  state_next = ST_PRIME;
            ST_PRIME:  state_next = ST_FETCH;
            ST_NEXT:   state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_MUL1;
            ST_MUL1:   if (step_reg == STEP_MUL1_END) state_next = ST_CHK;
            ST_CHK:
            begin
                if (dd_reg == '0)
                begin
                    state_next = ST_SEGEND;
                end
                else if (dot0_reg <= 0 || dot1_reg >= 0)
                begin
                    state_next = ST_UPD;
                end
                else
                begin
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:   if (step_reg == STEP_MUL2_END) state_next = ST_DIVS;
            ST_DIVS:   state_next = ST_DIVW;
            ST_DIVW:   if (!div_busy) state_next = ST_UPD;
            ST_UPD:    state_next = ST_SEGEND;
            ST_SEGEND:
            begin
                if ((CNT_W'(idx_reg) + CNT_W'(2)) < cnt_reg)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = found_reg ? ST_SQS : ST_FIN;
                end
            end
            ST_SQS:    state_next = ST_SQW;
            ST_SQW:    if (!sq_busy) state_next = ST_FIN;
            ST_FIN:    if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Clear, append or start a query on an accepted transfer
            if (in_fire)
            begin
                if (action == ACT_CLEAR)
                begin
                    cnt_reg <= '0;
                end
                else if (action == ACT_APPEND && cnt_reg < CNT_W'(MAX_POINTS))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else if (action == ACT_QUERY)
                begin
                    found_reg <= 1'b0;
                    idx_reg   <= '0;
                end
            end

            // Advance the multiply schedule
            if (state_reg == ST_FETCH)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_MUL1 || state_reg == ST_MUL2)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (state_reg == ST_UPD)
            begin
                found_reg <= 1'b1;
            end

            if (state_reg == ST_SEGEND && state_next == ST_NEXT)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            // Output register: load from the end of a query, drop on transfer
            if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire && action == ACT_QUERY)
        begin
            q_reg[0] <= coord_x;
            q_reg[1] <= coord_y;
            q_reg[2] <= coord_z;
        end

        if (state_reg == ST_PRIME)
        begin
            p0_reg <= rd_c;
        end
        else if (state_reg == ST_SEGEND)
        begin
            p0_reg <= p1_reg;
        end

        // Form the segment direction and both endpoint offsets
        if (state_reg == ST_FETCH)
        begin
            p1_reg <= rd_c;
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k] <= DIFF_W'(rd_c[k]) - DIFF_W'(p0_reg[k]);
                w_reg[k] <= DIFF_W'(q_reg[k]) - DIFF_W'(p0_reg[k]);
                v_reg[k] <= DIFF_W'(q_reg[k]) - DIFF_W'(rd_c[k]);
            end
        end

        // Pick the squared distance of this segment
        if (state_reg == ST_CHK)
        begin
            e_reg <= (dot0_reg <= 0) ? ww_reg : vv_reg;
        end
        else if (state_reg == ST_DIVW && !div_busy)
        begin
            e_reg <= div_quo;
        end

        if (state_reg == ST_UPD && (!found_reg || e_reg < best_reg))
        begin
            best_reg <= e_reg;
        end

        if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
        begin
            dist_reg  <= found_reg ? sq_root : '1;
            noseg_reg <= !found_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign distance   = dist_reg;
    assign no_segment = noseg_reg;

    // Vertex count stays within the store
    `PPD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_POINTS))

    // A fetched segment always ends on a stored vertex
    `PPD_ASSERT_NOW(a_seg_in_store, state_reg == ST_FETCH, (CNT_W'(idx_reg) + CNT_W'(1)) < cnt_reg)

    // A result appears only from the end of a query
    `PPD_ASSERT_NEXT(a_out_from_fin, !out_valid_reg && state_reg != ST_FIN, !out_valid_reg)

    // The divider runs only while the sequencer waits on it
    `PPD_ASSERT_NOW(a_div_owned, div_busy, state_reg == ST_DIVW)

endmodule

`default_nettype wire
